// ----- rtl/core/drt_pkg.sv -----
// Shared constants and types for the dirty region tracker.
package drt_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_MARK_RECT = 2'd0,
    OP_MARK_CELL = 2'd1,
    OP_FETCH     = 2'd2
  } op_t;

  localparam int OP_BITS = 2;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_ROWS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_COLS = 2'd1;

  // Screen size after reset
  localparam int RESET_SCREEN_ROWS = 25;
  localparam int RESET_SCREEN_COLS = 80;

  // Axis masks
  localparam int MASK_BITS     = 64;
  localparam int MASK_IDX_BITS = 6;

endpackage

// ----- rtl/core/drt_span_mask.sv -----
// Span [begin, end) modulo 64 as a 64-bit mask, all ones for long or empty spans.
module drt_span_mask #(
  parameter int COORD_BITS = 13
) (
  input  logic [COORD_BITS-1:0]          span_begin,
  input  logic [COORD_BITS-1:0]          span_end,
  output logic [drt_pkg::MASK_BITS-1:0]  mask
);

  localparam logic [drt_pkg::MASK_BITS-1:0] ONES = '1;

  logic [COORD_BITS-1:0]             len;
  logic                              long_span;
  logic [drt_pkg::MASK_IDX_BITS-1:0] lo_sh;
  logic [drt_pkg::MASK_IDX_BITS-1:0] hi_sh;
  logic [drt_pkg::MASK_BITS-1:0]     lo;
  logic [drt_pkg::MASK_BITS-1:0]     hi;
  logic [drt_pkg::MASK_BITS-1:0]     both;

  always_comb begin
    len       = span_end - span_begin;
    long_span = |len[COORD_BITS-1:drt_pkg::MASK_IDX_BITS];
    lo_sh     = span_begin[drt_pkg::MASK_IDX_BITS-1:0];
    // (64 - e) mod 64 is the 6-bit negation of e
    hi_sh     = -span_end[drt_pkg::MASK_IDX_BITS-1:0];
    lo        = ONES << lo_sh;
    hi        = ONES >> hi_sh;
    both      = lo & hi;
    if (long_span) begin
      mask = ONES;
    end else if (both == '0) begin
      // wrapped span (or empty span) takes the union
      mask = lo | hi;
    end else begin
      mask = both;
    end
  end

endmodule

// ----- rtl/core/drt_accum.sv -----
// Screen size registers and the accumulated dirty rectangle and masks.
module drt_accum #(
  parameter int COORD_BITS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [drt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  input  logic                                step,
  input  logic [drt_pkg::OP_BITS-1:0]         op,
  input  logic [COORD_BITS-1:0]               begin_row,
  input  logic [COORD_BITS-1:0]               begin_col,
  input  logic [COORD_BITS-1:0]               end_row,
  input  logic [COORD_BITS-1:0]               end_col,
  output logic [COORD_BITS-1:0]               acc_begin_row,
  output logic [COORD_BITS-1:0]               acc_begin_col,
  output logic [COORD_BITS-1:0]               acc_end_row,
  output logic [COORD_BITS-1:0]               acc_end_col,
  output logic [drt_pkg::MASK_BITS-1:0]       acc_row_mask,
  output logic [drt_pkg::MASK_BITS-1:0]       acc_col_mask
);

  logic [COORD_BITS-1:0]         screen_rows;
  logic [COORD_BITS-1:0]         screen_cols;
  logic [COORD_BITS-1:0]         mark_end_row;
  logic [COORD_BITS-1:0]         mark_end_col;
  logic [drt_pkg::MASK_BITS-1:0] row_span;
  logic [drt_pkg::MASK_BITS-1:0] col_span;

  // a single cell ends one past its coordinate, wrapping
  always_comb begin
    if (op == drt_pkg::OP_MARK_CELL) begin
      mark_end_row = begin_row + COORD_BITS'(1);
      mark_end_col = begin_col + COORD_BITS'(1);
    end else begin
      mark_end_row = end_row;
      mark_end_col = end_col;
    end
  end

  drt_span_mask #(.COORD_BITS(COORD_BITS)) u_row_span (
    .span_begin (begin_row),
    .span_end   (mark_end_row),
    .mask       (row_span)
  );

  drt_span_mask #(.COORD_BITS(COORD_BITS)) u_col_span (
    .span_begin (begin_col),
    .span_end   (mark_end_col),
    .mask       (col_span)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows   <= COORD_BITS'(drt_pkg::RESET_SCREEN_ROWS);
      screen_cols   <= COORD_BITS'(drt_pkg::RESET_SCREEN_COLS);
      acc_begin_row <= COORD_BITS'(drt_pkg::RESET_SCREEN_ROWS);
      acc_begin_col <= COORD_BITS'(drt_pkg::RESET_SCREEN_COLS);
      acc_end_row   <= '0;
      acc_end_col   <= '0;
      acc_row_mask  <= '0;
      acc_col_mask  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          drt_pkg::CFG_SCREEN_ROWS: screen_rows <= cfg_data;
          drt_pkg::CFG_SCREEN_COLS: screen_cols <= cfg_data;
          default: ;
        endcase
      end
      if (step) begin
        case (op)
          drt_pkg::OP_MARK_RECT, drt_pkg::OP_MARK_CELL: begin
            if (begin_row < acc_begin_row) acc_begin_row <= begin_row;
            if (begin_col < acc_begin_col) acc_begin_col <= begin_col;
            if (mark_end_row > acc_end_row) acc_end_row <= mark_end_row;
            if (mark_end_col > acc_end_col) acc_end_col <= mark_end_col;
            acc_row_mask <= acc_row_mask | row_span;
            acc_col_mask <= acc_col_mask | col_span;
          end
          drt_pkg::OP_FETCH: begin
            acc_begin_row <= screen_rows;
            acc_begin_col <= screen_cols;
            acc_end_row   <= '0;
            acc_end_col   <= '0;
            acc_row_mask  <= '0;
            acc_col_mask  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/dirty_region_tracker_unit.sv -----
// Dirty region tracker top level: input register, accumulator, result register.
//
//   channel  dir  accept               content
//   s_*      in   s_tvalid & s_tready  one operation word
//   m_*      out  m_tvalid & m_tready  rectangle and masks, one per fetch
//   cfg_*    in   cfg_we               screen_rows (index 0), screen_cols (1)
//
// One word per cycle unless a fetch word stalls; a word sits in the input
// register, where it updates the accumulator; fetch results are registered.
// Reset (rst, synchronous) loads screen size 25 x 80 and clears the region.
// Mark words keep flowing while a fetch result waits; only a fetch word stalls
// in the input register until the result register is free.
module dirty_region_tracker_unit #(
  parameter int COORD_BITS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // operation, begin_row, begin_col, end_row, end_col (low first), zero padded
  input  logic [((drt_pkg::OP_BITS + 4*COORD_BITS + 7)/8)*8-1:0] s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // dirty_begin_row, dirty_begin_col, dirty_end_row, dirty_end_col,
  // row_mask, col_mask (low first), zero padded
  output logic [((4*COORD_BITS + 2*drt_pkg::MASK_BITS + 7)/8)*8-1:0] m_tdata,
  input  logic                                cfg_we,
  input  logic [drt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data
);

  localparam int CB       = COORD_BITS;
  localparam int OB       = drt_pkg::OP_BITS;
  localparam int MB       = drt_pkg::MASK_BITS;
  localparam int OUT_BITS = 4*CB + 2*MB;
  localparam int OUT_W    = ((OUT_BITS + 7)/8)*8;

  // input register
  logic           in_valid;
  logic [OB-1:0]  in_op;
  logic [CB-1:0]  in_begin_row;
  logic [CB-1:0]  in_begin_col;
  logic [CB-1:0]  in_end_row;
  logic [CB-1:0]  in_end_col;

  // result register
  logic           res_valid;
  logic [CB-1:0]  res_begin_row;
  logic [CB-1:0]  res_begin_col;
  logic [CB-1:0]  res_end_row;
  logic [CB-1:0]  res_end_col;
  logic [MB-1:0]  res_row_mask;
  logic [MB-1:0]  res_col_mask;

  logic           is_fetch;
  logic           advance;
  logic           fetch_take;
  logic [CB-1:0]  acc_begin_row;
  logic [CB-1:0]  acc_begin_col;
  logic [CB-1:0]  acc_end_row;
  logic [CB-1:0]  acc_end_col;
  logic [MB-1:0]  acc_row_mask;
  logic [MB-1:0]  acc_col_mask;

  assign is_fetch   = (in_op == drt_pkg::OP_FETCH);
  assign advance    = in_valid && (!is_fetch || !res_valid || m_tready);
  assign fetch_take = advance && is_fetch;
  assign s_tready   = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_op        <= s_tdata[OB-1:0];
      in_begin_row <= s_tdata[OB +     CB - 1 -: CB];
      in_begin_col <= s_tdata[OB + 2 * CB - 1 -: CB];
      in_end_row   <= s_tdata[OB + 3 * CB - 1 -: CB];
      in_end_col   <= s_tdata[OB + 4 * CB - 1 -: CB];
    end
  end

  drt_accum #(.COORD_BITS(CB)) u_accum (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .step          (advance),
    .op            (in_op),
    .begin_row     (in_begin_row),
    .begin_col     (in_begin_col),
    .end_row       (in_end_row),
    .end_col       (in_end_col),
    .acc_begin_row (acc_begin_row),
    .acc_begin_col (acc_begin_col),
    .acc_end_row   (acc_end_row),
    .acc_end_col   (acc_end_col),
    .acc_row_mask  (acc_row_mask),
    .acc_col_mask  (acc_col_mask)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fetch_take) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
    if (fetch_take) begin
      res_begin_row <= acc_begin_row;
      res_begin_col <= acc_begin_col;
      res_end_row   <= acc_end_row;
      res_end_col   <= acc_end_col;
      res_row_mask  <= acc_row_mask;
      res_col_mask  <= acc_col_mask;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = OUT_W'({res_col_mask, res_row_mask, res_end_col, res_end_row,
                            res_begin_col, res_begin_row});

endmodule
